FILE: src/odo_pkg.sv
// Package for the differential-drive odometry block: payload types, codes and CORDIC table.
`default_nettype none
package odo_pkg;

    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
    } t_odo_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [15:0] heading;
    } t_odo_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_T,
        ST_MUL_A,
        ST_ANGLE,
        ST_ROT,
        ST_MUL_X,
        ST_MUL_Y,
        ST_ACC_Y,
        ST_OUT
    } t_state;

    localparam logic [7:0] CFG_DIST_PER_COUNT  = 8'd0;
    localparam logic [7:0] CFG_ANGLE_PER_COUNT = 8'd1;

    localparam logic [31:0] DIST_PER_COUNT_RST  = 32'd622907;
    localparam logic [31:0] ANGLE_PER_COUNT_RST = 32'd50758000;

    localparam int CORDIC_MAX = 24;
    localparam logic signed [32:0] CORDIC_GAIN_INV = 33'sd652032874;
    localparam logic signed [15:0] DELTA_LIMIT = 16'sd32767;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [29:0] atan_turn(input logic [4:0] idx);
        logic [29:0] v;
        begin
            unique case (idx)
                5'd0:    v = 30'd536870912;
                5'd1:    v = 30'd316933406;
                5'd2:    v = 30'd167458907;
                5'd3:    v = 30'd85004756;
                5'd4:    v = 30'd42667331;
                5'd5:    v = 30'd21354465;
                5'd6:    v = 30'd10679838;
                5'd7:    v = 30'd5340245;
                5'd8:    v = 30'd2670163;
                5'd9:    v = 30'd1335087;
                5'd10:   v = 30'd667544;
                5'd11:   v = 30'd333772;
                5'd12:   v = 30'd166886;
                5'd13:   v = 30'd83443;
                5'd14:   v = 30'd41722;
                5'd15:   v = 30'd20861;
                5'd16:   v = 30'd10430;
                5'd17:   v = 30'd5215;
                5'd18:   v = 30'd2608;
                5'd19:   v = 30'd1304;
                5'd20:   v = 30'd652;
                5'd21:   v = 30'd326;
                5'd22:   v = 30'd163;
                5'd23:   v = 30'd81;
                default: v = 30'd0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

FILE: src/diff_drive_odometry.sv
// Top level of the differential-drive wheel odometry block with its shared multiplier and CORDIC.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+---------------------------------
//   in       | to block  | i_in_valid / o_in_ready    | i_in_data  (left, right count)
//   out      | from block| o_out_valid / i_out_ready  | o_out_data (pos_x, pos_y, heading)
//   cfg      | to block  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A request runs from acceptance to the result register through the CORDIC rotation loop,
// one micro-rotation per cycle, plus four passes through the single 33x33 multiplier and the
// accumulate steps. The input reopens only once the result register is loaded, so a new
// request is accepted only after the previous one has passed its output step.
// Reset is synchronous, active low, and clears position, heading, previous counts and
// restores the register defaults. A stalled result holds in the output register; the block
// finishes its current request and only then waits for the output to drain.
`default_nettype none
module diff_drive_odometry #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire odo_pkg::t_odo_in  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output odo_pkg::t_odo_out      o_out_data,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [7:0]        i_cfg_index,
    input  wire logic [31:0]       i_cfg_data
);

    localparam int STEPS  = (CORDIC_STEPS > odo_pkg::CORDIC_MAX) ? odo_pkg::CORDIC_MAX
                                                                : CORDIC_STEPS;
    localparam int ITER_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    odo_pkg::t_state r_state, n_state;

    logic [31:0]        r_dist_per_count, r_angle_per_count;
    logic [31:0]        r_left_prev, r_right_prev;
    logic signed [31:0] r_x_acc, r_y_acc;
    logic [15:0]        r_yaw_acc;
    logic [ITER_W-1:0]  r_iter;
    logic               r_out_valid;
    odo_pkg::t_odo_out  r_out_data;

    logic signed [16:0] r_sum, r_diff;
    logic signed [65:0] r_prod;
    logic signed [31:0] r_travel;
    logic signed [32:0] r_cx, r_cy;
    logic signed [31:0] r_cz;
    logic [1:0]         r_quad;

    logic               in_take;
    logic signed [15:0] dl, dr;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [31:0]        mid;
    logic signed [32:0] cx_sh, cy_sh;
    logic signed [31:0] atan_v;
    logic signed [32:0] trig_c, trig_s;
    logic               iter_last;
    logic               out_load;

    function automatic logic signed [15:0] f_delta(input logic [31:0] now,
                                                   input logic [31:0] prev);
        logic signed [31:0] d;
        begin
            d = signed'(now - prev);
            if (d > 32'(odo_pkg::DELTA_LIMIT)) begin
                return odo_pkg::DELTA_LIMIT;
            end else if (d < -32'(odo_pkg::DELTA_LIMIT)) begin
                return -odo_pkg::DELTA_LIMIT;
            end
            return d[15:0];
        end
    endfunction

    function automatic logic signed [31:0] f_sat(input logic signed [65:0] v);
        begin
            if (v > 66'sd2147483647) begin
                return 32'sh7FFF_FFFF;
            end else if (v < -66'sd2147483648) begin
                return 32'sh8000_0000;
            end
            return v[31:0];
        end
    endfunction

    assign in_take     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign dl          = f_delta(i_in_data.left_count, r_left_prev);
    assign dr          = f_delta(i_in_data.right_count, r_right_prev);
    assign iter_last   = (r_iter == ITER_W'(STEPS - 1));
    assign out_load    = (r_state == odo_pkg::ST_OUT) && (!r_out_valid || i_out_ready);

    // Midpoint heading: stored yaw plus half the heading change, as a 32-bit binary angle.
    assign mid = {r_yaw_acc, 16'd0} + r_prod[32:1];

    assign cx_sh  = r_cx >>> r_iter;
    assign cy_sh  = r_cy >>> r_iter;
    assign atan_v = signed'({2'b00, odo_pkg::atan_turn(5'(r_iter))});

    always_comb begin
        unique case (r_quad)
            2'd0: begin
                trig_c = r_cx;
                trig_s = r_cy;
            end
            2'd1: begin
                trig_c = -r_cy;
                trig_s = r_cx;
            end
            2'd2: begin
                trig_c = -r_cx;
                trig_s = -r_cy;
            end
            default: begin
                trig_c = r_cy;
                trig_s = -r_cx;
            end
        endcase
    end

    // The one multiplier, shared by travel, heading change and both projections.
    always_comb begin
        case (r_state)
            odo_pkg::ST_MUL_T: begin
                mul_a = 33'(r_sum);
                mul_b = signed'({1'b0, r_dist_per_count});
            end
            odo_pkg::ST_MUL_A: begin
                mul_a = 33'(r_diff);
                mul_b = signed'({1'b0, r_angle_per_count});
            end
            odo_pkg::ST_MUL_X: begin
                mul_a = 33'(r_travel);
                mul_b = trig_c;
            end
            odo_pkg::ST_MUL_Y: begin
                mul_a = 33'(r_travel);
                mul_b = trig_s;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = 66'(mul_a) * 66'(mul_b);

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        unique case (r_state)
            odo_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = odo_pkg::ST_MUL_T;
                end
            end
            odo_pkg::ST_MUL_T: n_state = odo_pkg::ST_MUL_A;
            odo_pkg::ST_MUL_A: n_state = odo_pkg::ST_ANGLE;
            odo_pkg::ST_ANGLE: n_state = odo_pkg::ST_ROT;
            odo_pkg::ST_ROT: begin
                if (iter_last) begin
                    n_state = odo_pkg::ST_MUL_X;
                end
            end
            odo_pkg::ST_MUL_X: n_state = odo_pkg::ST_MUL_Y;
            odo_pkg::ST_MUL_Y: n_state = odo_pkg::ST_ACC_Y;
            odo_pkg::ST_ACC_Y: n_state = odo_pkg::ST_OUT;
            odo_pkg::ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = odo_pkg::ST_IDLE;
                end
            end
            default: n_state = odo_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= odo_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_per_count  <= odo_pkg::DIST_PER_COUNT_RST;
            r_angle_per_count <= odo_pkg::ANGLE_PER_COUNT_RST;
            r_left_prev       <= '0;
            r_right_prev      <= '0;
            r_x_acc           <= '0;
            r_y_acc           <= '0;
            r_yaw_acc         <= '0;
            r_iter            <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    odo_pkg::CFG_DIST_PER_COUNT:  r_dist_per_count  <= i_cfg_data;
                    odo_pkg::CFG_ANGLE_PER_COUNT: r_angle_per_count <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_take) begin
                r_left_prev  <= i_in_data.left_count;
                r_right_prev <= i_in_data.right_count;
            end
            if (r_state == odo_pkg::ST_ANGLE) begin
                r_yaw_acc <= r_yaw_acc + r_prod[31:16];
                r_iter    <= '0;
            end else if (r_state == odo_pkg::ST_ROT) begin
                r_iter <= r_iter + ITER_W'(1);
            end
            if (r_state == odo_pkg::ST_MUL_Y) begin
                r_x_acc <= f_sat(66'(r_x_acc) + (r_prod >>> 30));
            end
            if (r_state == odo_pkg::ST_ACC_Y) begin
                r_y_acc <= f_sat(66'(r_y_acc) + (r_prod >>> 30));
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (in_take) begin
            r_sum  <= 17'(dl) + 17'(dr);
            r_diff <= 17'(dr) - 17'(dl);
        end
        if (r_state == odo_pkg::ST_MUL_A) begin
            r_travel <= f_sat(r_prod >>> 9);
        end
        if (r_state == odo_pkg::ST_ANGLE) begin
            // Fold the angle into [-1/8, 1/8) turn; the low 30 bits read as signed give z.
            r_cx   <= odo_pkg::CORDIC_GAIN_INV;
            r_cy   <= '0;
            r_cz   <= 32'(signed'(mid[29:0]));
            r_quad <= mid[31:30] + 2'(mid[29]);
        end else if (r_state == odo_pkg::ST_ROT) begin
            if (r_cz >= 0) begin
                r_cx <= r_cx - cy_sh;
                r_cy <= r_cy + cx_sh;
                r_cz <= r_cz - atan_v;
            end else begin
                r_cx <= r_cx + cy_sh;
                r_cy <= r_cy - cx_sh;
                r_cz <= r_cz + atan_v;
            end
        end
        if (out_load) begin
            r_out_data.pos_x   <= r_x_acc;
            r_out_data.pos_y   <= r_y_acc;
            r_out_data.heading <= r_yaw_acc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // An accepted request always starts with the travel multiply.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state == odo_pkg::ST_MUL_T))
        else $error("accepted request did not start the sequence");

    // A new result only appears after the sequencer reached its output step.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == odo_pkg::ST_OUT))
        else $error("result raised outside the output step");

    // The rotation loop leaves only after its last micro-rotation.
    a_rot_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == odo_pkg::ST_ROT) && !iter_last |=> (r_state == odo_pkg::ST_ROT))
        else $error("CORDIC loop left early");

endmodule
`default_nettype wire
